>>> rtl/core/gdsrd_pkg.sv
// ----------------------------------------------------------------------------
// GDSII real / IEEE double converter package
// Function codes, status codes and field widths shared by the converter.
// ----------------------------------------------------------------------------
package gdsrd_pkg;

    typedef enum logic [1:0] {
        FUNC_G8_TO_D = 2'd0,
        FUNC_G4_TO_D = 2'd1,
        FUNC_D_TO_G8 = 2'd2,
        FUNC_D_TO_G4 = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    localparam int WORD_W = 64;
    localparam int IN_TDATA_W = 72;  // func(2) + word_in(64), padded to bytes
    localparam int OUT_TDATA_W = 72; // word_out(64) + status(2), padded

    typedef struct packed {
        logic [WORD_W-1:0] word;
        t_status           status;
    } t_result;

endpackage

>>> rtl/core/gdsrd_conv.sv
// ----------------------------------------------------------------------------
// GDSII real / IEEE double conversion datapath
// Combinational conversion of one registered item in all four directions.
// ----------------------------------------------------------------------------
module gdsrd_conv (
    input  gdsrd_pkg::t_func   i_func,
    input  logic [63:0]        i_word,
    output gdsrd_pkg::t_result o_res
);

    // decode side
    logic        d_sgn;
    logic [6:0]  d_ex;
    logic [55:0] d_frac;
    logic        d_wide;
    logic [5:0]  d_lz;
    logic [55:0] d_norm;
    logic [52:0] d_keep;
    logic [53:0] d_rnd;
    logic        d_rup;
    logic [12:0] d_exp;
    logic [63:0] d_out;
    // encode side
    logic        e_sgn;
    logic [10:0] e_bexp;
    logic [52:0] e_sig;
    logic [9:0]  e_g;
    logic [1:0]  e_sh;
    logic [55:0] e_mant;
    logic        e_wide;
    logic [63:0] e_zero;
    logic [63:0] e_out;
    gdsrd_pkg::t_status e_st;

    always_comb begin
        d_wide = (i_func == gdsrd_pkg::FUNC_G8_TO_D);
        if (d_wide) begin
            d_sgn  = i_word[63];
            d_ex   = i_word[62:56];
            d_frac = i_word[55:0];
        end else begin
            d_sgn  = i_word[31];
            d_ex   = i_word[30:24];
            d_frac = {i_word[23:0], 32'd0};
        end
        // count leading zeros of the 56-bit fraction
        d_lz = 6'd0;
        for (int i = 0; i < 56; i++) begin
            if (d_frac[i]) d_lz = 6'(55 - i);
        end
        d_norm = d_frac << d_lz;
        d_keep = d_norm[55:3];
        d_rup  = d_norm[2] && (d_norm[1] || d_norm[0] || d_norm[3]);
        d_rnd  = {1'b0, d_keep} + {53'd0, d_rup};
        // value = 1.x * 2^(4*(ex-64) - 1 - lz); carry out bumps the exponent
        d_exp = 13'(4 * {6'd0, d_ex}) - 13'd256 - 13'd1 - {7'd0, d_lz} + 13'd1023
              + {12'd0, d_rnd[53]};
        d_out = {d_sgn, d_exp[10:0], d_rnd[53] ? d_rnd[52:1] : d_rnd[51:0]};
        if (d_frac == 56'd0) d_out = {d_sgn, 63'd0};
    end

    always_comb begin
        e_wide = (i_func == gdsrd_pkg::FUNC_D_TO_G8);
        e_sgn  = i_word[63];
        e_bexp = i_word[62:52];
        e_sig  = {1'b1, i_word[51:0]};
        // g = floor(ue/4) + 65 computed from bexp: ue+1024 = bexp+1; spans -191..320
        e_g    = 10'(({1'b0, e_bexp} + 12'd1) >> 2) - 10'd255 + 10'd64;
        // shift = 4 - d = low bits of ue, i.e. (bexp+1) mod 4
        e_sh   = 2'(e_bexp + 11'd1);
        e_mant = {3'd0, e_sig} << e_sh;
        e_zero = e_wide ? {8'h40, 56'd0} : {32'd0, 8'h40, 24'd0};
        e_st   = gdsrd_pkg::ST_OK;
        if (e_bexp == 11'h7FF) begin
            e_out = 64'd0;
            e_st  = gdsrd_pkg::ST_INVALID;
        end else if (e_bexp == 11'd0) begin
            e_out = e_zero;
            if (i_word[51:0] != 52'd0) e_st = gdsrd_pkg::ST_UNDERFLOW;
        end else if (!e_g[9] && (e_g[8] || e_g[7])) begin
            e_out = e_wide ? {e_sgn, 7'h7F, 56'hFF_FFFF_FFFF_FFFF}
                           : {32'd0, e_sgn, 7'h7F, 24'hFF_FFFF};
            e_st  = gdsrd_pkg::ST_OVERFLOW;
        end else if (e_g[9]) begin
            e_out = e_zero;
            e_st  = gdsrd_pkg::ST_UNDERFLOW;
        end else begin
            e_out = e_wide ? {e_sgn, e_g[6:0], e_mant}
                           : {32'd0, e_sgn, e_g[6:0], e_mant[55:32]};
        end
    end

    always_comb begin
        unique case (i_func)
            gdsrd_pkg::FUNC_G8_TO_D, gdsrd_pkg::FUNC_G4_TO_D: begin
                o_res.word   = d_out;
                o_res.status = gdsrd_pkg::ST_OK;
            end
            default: begin
                o_res.word   = e_out;
                o_res.status = e_st;
            end
        endcase
    end

endmodule

>>> rtl/core/gdsii_real_ieee_double_convert.sv
// ----------------------------------------------------------------------------
// GDSII real / IEEE double converter
// Converts GDSII excess-64 base-16 reals to and from IEEE 754 doubles.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tdata carries func (bits 1:0) and word_in (65:2).
//   func selects gds8->double, gds4->double, double->gds8 or double->gds4.
//   Output stream m_axis: tdata carries word_out (63:0) and status (65:64).
//   Each transfer in gives exactly one transfer out, in order.
// Pipeline:
//   One input register, then the conversion logic (leading-zero count,
//   shift, round) feeding one result register.
//   Throughput is one item per cycle while m_axis_tready is high.
// Reset:
//   i_rst_n low clears both valid flags and drops any item in flight.
// Stall:
//   When m_axis_tready is low a full result register holds; the input
//   register still accepts while it is empty, so once both hold an item
//   s_axis_tready drops in the same cycle as m_axis_tready.
// ----------------------------------------------------------------------------
module gdsii_real_ieee_double_convert (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [gdsrd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // func, word_in
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [gdsrd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // word_out, status
);

    logic               r_in_vld;
    gdsrd_pkg::t_func   r_func;
    logic [63:0]        r_word;
    logic               r_out_vld;
    gdsrd_pkg::t_result r_res;
    gdsrd_pkg::t_result n_res;
    logic               out_ready;

    assign out_ready     = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || out_ready;

    gdsrd_conv u_conv (
        .i_func (r_func),
        .i_word (r_word),
        .o_res  (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_vld <= s_axis_tvalid;
            if (out_ready) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_func <= gdsrd_pkg::t_func'(s_axis_tdata[1:0]);
            r_word <= s_axis_tdata[65:2];
        end
        if (out_ready && r_in_vld) r_res <= n_res;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_res.status, r_res.word};

    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[71:66];

endmodule
